[hw/rtl/lbd_pkg.sv]
package lbd_pkg;

  // number of evaluated slots: button zero, button one, both together
  localparam int SLOTS = 3;

  localparam int SAMPLE_W = 12;
  localparam int COUNT_W  = 6;

  typedef logic [SAMPLE_W-1:0] sample_t;
  typedef logic [COUNT_W-1:0]  count_t;
  typedef logic [1:0]          level_t;
  typedef logic [2:0]          kind_t;
  typedef logic [1:0]          button_t;

  // button levels
  localparam level_t LVL_RELEASED = 2'd0;
  localparam level_t LVL_PRESSED  = 2'd1;
  localparam level_t LVL_HOLD     = 2'd2;

  // event kinds
  localparam kind_t EV_NONE          = 3'd0;
  localparam kind_t EV_PRESSED       = 3'd1;
  localparam kind_t EV_HOLD          = 3'd2;
  localparam kind_t EV_RELEASED      = 3'd3;
  localparam kind_t EV_HOLD_RELEASED = 3'd4;

  // register indexes (byte address / 4)
  localparam logic [2:0] REG_WIN0_LOW    = 3'd0;
  localparam logic [2:0] REG_WIN0_HIGH   = 3'd1;
  localparam logic [2:0] REG_WIN1_LOW    = 3'd2;
  localparam logic [2:0] REG_WIN1_HIGH   = 3'd3;
  localparam logic [2:0] REG_WIN2_LOW    = 3'd4;
  localparam logic [2:0] REG_WIN2_HIGH   = 3'd5;
  localparam logic [2:0] REG_PRESS_AFTER = 3'd6;
  localparam logic [2:0] REG_HOLD_AFTER  = 3'd7;

  // register reset values
  localparam sample_t WIN0_LOW_RST    = 12'd280;
  localparam sample_t WIN0_HIGH_RST   = 12'd380;
  localparam sample_t WIN1_LOW_RST    = 12'd610;
  localparam sample_t WIN1_HIGH_RST   = 12'd710;
  localparam sample_t WIN2_LOW_RST    = 12'd450;
  localparam sample_t WIN2_HIGH_RST   = 12'd550;
  localparam count_t  PRESS_AFTER_RST = 6'd1;
  localparam count_t  HOLD_AFTER_RST  = 6'd10;

  // exclusive sample window of one slot
  typedef struct packed {
    sample_t low;
    sample_t high;
  } win_t;

  // next state and event of one slot
  typedef struct packed {
    count_t cnt;
    level_t level;
    kind_t  kind;
  } slot_upd_t;

endpackage

[hw/rtl/lbd_slot.sv]
module lbd_slot #(
  parameter int COUNT_LIMIT = 50
) (
  input  lbd_pkg::sample_t   sample,
  input  lbd_pkg::win_t      win,
  input  lbd_pkg::count_t    press_after,
  input  lbd_pkg::count_t    hold_after,
  input  lbd_pkg::count_t    cnt,
  input  lbd_pkg::level_t    level,
  output lbd_pkg::slot_upd_t upd
);
  import lbd_pkg::*;

  localparam count_t LIMIT = count_t'(COUNT_LIMIT);

  logic   in_win;
  count_t cnt_nxt;
  level_t level_nxt;
  kind_t  kind;

  // count up inside the window, saturate at the limit, clear outside
  assign in_win = (sample > win.low) && (sample < win.high);

  always_comb begin
    if (!in_win) begin
      cnt_nxt = '0;
    end else if (cnt < LIMIT) begin
      cnt_nxt = cnt + count_t'(1);
    end else begin
      cnt_nxt = cnt;
    end
  end

  // derive the level from the new count
  always_comb begin
    if (cnt_nxt == '0) begin
      level_nxt = LVL_RELEASED;
    end else if (cnt_nxt > hold_after) begin
      level_nxt = LVL_HOLD;
    end else if (cnt_nxt > press_after) begin
      level_nxt = LVL_PRESSED;
    end else begin
      level_nxt = level;
    end
  end

  // map the level transition to an event
  always_comb begin
    kind = EV_NONE;
    if (level == LVL_RELEASED && level_nxt == LVL_PRESSED) begin
      kind = EV_PRESSED;
    end else if (level == LVL_PRESSED && level_nxt == LVL_HOLD) begin
      kind = EV_HOLD;
    end else if (level == LVL_PRESSED && level_nxt == LVL_RELEASED) begin
      kind = EV_RELEASED;
    end else if (level == LVL_HOLD && level_nxt == LVL_RELEASED) begin
      kind = EV_HOLD_RELEASED;
    end
  end

  assign upd.cnt   = cnt_nxt;
  assign upd.level = level_nxt;
  assign upd.kind  = kind;

endmodule

[hw/rtl/ladder_button_debouncer.sv]
// Debouncer for a two-button resistor-ladder keypad. Each input transaction carries one
// 12-bit ADC sample; each output transaction carries the event it caused (button index and
// kind, both zero when nothing changed) and the levels of button zero, button one and the
// both-buttons combination. A sample is registered on entry and evaluated in the following
// cycle against the three windows and debounce counters, so the block takes one sample per
// cycle while the output is not stalled. Windows and thresholds are set through the APB port
// at byte addresses 0x00 to 0x1C; change them only while no sample is in flight.
module ladder_button_debouncer #(
  parameter int BUTTONS     = 3,
  parameter int COUNT_LIMIT = 50
) (
  input  logic        clk,
  input  logic        rst_n,
  // in_tdata: [11:0] sample
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,
  // out_tdata: [1:0] event_button, [4:2] event_kind, [6:5] state_zero,
  //            [8:7] state_one, [10:9] state_two
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import lbd_pkg::*;

  win_t      win_r [SLOTS];
  count_t    press_after_r;
  count_t    hold_after_r;

  count_t    cnt_r [SLOTS];
  level_t    level_r [SLOTS];
  slot_upd_t upd [SLOTS];

  logic      s1_valid_r;
  sample_t   s1_sample_r;
  logic      s1_adv;

  logic      out_valid_r;
  button_t   ev_button_r;
  kind_t     ev_kind_r;
  level_t    state_r [SLOTS];

  button_t   ev_button_nxt;
  kind_t     ev_kind_nxt;

  logic      cfg_wr;
  logic [2:0] cfg_idx;

  // configuration registers
  assign cfg_pready = 1'b1;
  assign cfg_idx    = cfg_paddr[4:2];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r[0]      <= '{low: WIN0_LOW_RST, high: WIN0_HIGH_RST};
      win_r[1]      <= '{low: WIN1_LOW_RST, high: WIN1_HIGH_RST};
      win_r[2]      <= '{low: WIN2_LOW_RST, high: WIN2_HIGH_RST};
      press_after_r <= PRESS_AFTER_RST;
      hold_after_r  <= HOLD_AFTER_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_WIN0_LOW:    win_r[0].low   <= cfg_pwdata[SAMPLE_W-1:0];
        REG_WIN0_HIGH:   win_r[0].high  <= cfg_pwdata[SAMPLE_W-1:0];
        REG_WIN1_LOW:    win_r[1].low   <= cfg_pwdata[SAMPLE_W-1:0];
        REG_WIN1_HIGH:   win_r[1].high  <= cfg_pwdata[SAMPLE_W-1:0];
        REG_WIN2_LOW:    win_r[2].low   <= cfg_pwdata[SAMPLE_W-1:0];
        REG_WIN2_HIGH:   win_r[2].high  <= cfg_pwdata[SAMPLE_W-1:0];
        REG_PRESS_AFTER: press_after_r  <= cfg_pwdata[COUNT_W-1:0];
        REG_HOLD_AFTER:  hold_after_r   <= cfg_pwdata[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // register read back
  always_comb begin
    case (cfg_idx)
      REG_WIN0_LOW:    cfg_prdata = 32'(win_r[0].low);
      REG_WIN0_HIGH:   cfg_prdata = 32'(win_r[0].high);
      REG_WIN1_LOW:    cfg_prdata = 32'(win_r[1].low);
      REG_WIN1_HIGH:   cfg_prdata = 32'(win_r[1].high);
      REG_WIN2_LOW:    cfg_prdata = 32'(win_r[2].low);
      REG_WIN2_HIGH:   cfg_prdata = 32'(win_r[2].high);
      REG_PRESS_AFTER: cfg_prdata = 32'(press_after_r);
      REG_HOLD_AFTER:  cfg_prdata = 32'(hold_after_r);
      default:         cfg_prdata = '0;
    endcase
  end

  // input stage: advance when the result register is free or draining
  assign s1_adv    = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_sample_r <= in_tdata[SAMPLE_W-1:0];
    end
  end

  // per-slot evaluation; slots beyond BUTTONS stay released
  for (genvar g = 0; g < SLOTS; g++) begin : g_slot
    if (g < BUTTONS) begin : g_on
      lbd_slot #(
        .COUNT_LIMIT(COUNT_LIMIT)
      ) u_slot (
        .sample      (s1_sample_r),
        .win         (win_r[g]),
        .press_after (press_after_r),
        .hold_after  (hold_after_r),
        .cnt         (cnt_r[g]),
        .level       (level_r[g]),
        .upd         (upd[g])
      );
    end else begin : g_off
      assign upd[g] = '{cnt: '0, level: LVL_RELEASED, kind: EV_NONE};
    end
  end

  // highest-numbered slot with an event wins
  always_comb begin
    ev_button_nxt = '0;
    ev_kind_nxt   = EV_NONE;
    for (int i = 0; i < SLOTS; i++) begin
      if (upd[i].kind != EV_NONE) begin
        ev_button_nxt = button_t'(i);
        ev_kind_nxt   = upd[i].kind;
      end
    end
  end

  // commit slot state as the sample moves into the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SLOTS; i++) begin
        cnt_r[i]   <= '0;
        level_r[i] <= LVL_RELEASED;
      end
    end else if (s1_adv) begin
      for (int i = 0; i < SLOTS; i++) begin
        cnt_r[i]   <= upd[i].cnt;
        level_r[i] <= upd[i].level;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      ev_button_r <= ev_button_nxt;
      ev_kind_r   <= ev_kind_nxt;
      for (int i = 0; i < SLOTS; i++) begin
        state_r[i] <= upd[i].level;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'd0, state_r[2], state_r[1], state_r[0], ev_kind_r, ev_button_r};

`ifndef NO_ASSERTIONS
  // no event reports button zero
  a_no_event_button: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && ev_kind_r == EV_NONE |-> ev_button_r == '0)
    else $error("event_button set without an event");

  // counters never pass the saturation limit
  a_count_limit: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r[0] <= count_t'(COUNT_LIMIT) && cnt_r[1] <= count_t'(COUNT_LIMIT)
      && cnt_r[2] <= count_t'(COUNT_LIMIT))
    else $error("debounce count above limit");

  // a cleared counter always means a released slot
  a_zero_released: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r[0] != '0 || level_r[0] == LVL_RELEASED)
      && (cnt_r[1] != '0 || level_r[1] == LVL_RELEASED)
      && (cnt_r[2] != '0 || level_r[2] == LVL_RELEASED))
    else $error("slot not released with zero count");

  // an evaluated sample always yields a result next cycle
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv |=> out_tvalid)
    else $error("evaluated sample produced no result");

  // reported states match the committed slot levels
  a_state_match: assert property (@(posedge clk) disable iff (!rst_n)
    $past(s1_adv) |-> state_r[0] == level_r[0] && state_r[1] == level_r[1]
      && state_r[2] == level_r[2])
    else $error("reported state differs from slot level");
`endif

endmodule

[sim/ladder_button_debouncer_tb.sv]
module ladder_button_debouncer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lbd_pkg::*;

  localparam int BUTTONS         = 3;
  localparam int COUNT_LIMIT     = 50;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int QUIET_LIMIT     = 2000;

  // one decoded result transaction
  typedef struct {
    button_t button;
    kind_t   kind;
    level_t  zero;
    level_t  one;
    level_t  two;
  } ladder_result_t;

  logic        clk         = 1'b0;
  logic        rst_n       = 1'b0;
  logic        in_tvalid   = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata    = '0;     // [11:0] sample
  logic        out_tvalid;
  logic        out_tready  = 1'b0;
  logic [15:0] out_tdata;            // [1:0] event_button, [4:2] event_kind, [6:5] state_zero,
                                     // [8:7] state_one, [10:9] state_two
  logic        cfg_psel    = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite  = 1'b0;
  logic [4:0]  cfg_paddr   = '0;
  logic [31:0] cfg_pwdata  = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  // register copies used for prediction
  sample_t win_lo [SLOTS] = '{WIN0_LOW_RST, WIN1_LOW_RST, WIN2_LOW_RST};
  sample_t win_hi [SLOTS] = '{WIN0_HIGH_RST, WIN1_HIGH_RST, WIN2_HIGH_RST};
  count_t  press_th = PRESS_AFTER_RST;
  count_t  hold_th  = HOLD_AFTER_RST;

  // debounce state of the predictor
  count_t  debounce_cnt [SLOTS] = '{default: '0};
  level_t  btn_level    [SLOTS] = '{default: LVL_RELEASED};

  ladder_result_t pending_results[$];

  int in_idle_pct   = 12;
  int out_idle_pct  = 66;
  int hold_off_seq  = 0;
  int hold_off_seen = 0;
  int stall_left    = 0;
  int quiet_cycles  = 0;
  int mismatches    = 0;
  int samples_sent  = 0;
  int results_seen  = 0;
  int kind_seen [5] = '{default: 0};

  ladder_button_debouncer #(
    .BUTTONS     (BUTTONS),
    .COUNT_LIMIT (COUNT_LIMIT)
  ) u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // advance the debounce state by one sample and return the result it gives
  function automatic ladder_result_t debounce_step(input sample_t s);
    ladder_result_t r;
    level_t lvl_new;
    kind_t  ev;
    int     b;
    r.button = '0;
    r.kind   = EV_NONE;
    for (b = 0; b < BUTTONS && b < SLOTS; b++) begin
      if (win_lo[b] < s && s < win_hi[b]) begin
        if (debounce_cnt[b] < COUNT_LIMIT) debounce_cnt[b] = debounce_cnt[b] + 1'b1;
      end else begin
        debounce_cnt[b] = '0;
      end
      // level follows the count; from one up to the lower of press_th and hold_th it is kept
      lvl_new = btn_level[b];
      if (debounce_cnt[b] == 0) lvl_new = LVL_RELEASED;
      else if (debounce_cnt[b] > hold_th) lvl_new = LVL_HOLD;
      else if (debounce_cnt[b] > press_th) lvl_new = LVL_PRESSED;
      // only the four regular transitions raise an event
      ev = EV_NONE;
      if (btn_level[b] == LVL_RELEASED && lvl_new == LVL_PRESSED) ev = EV_PRESSED;
      else if (btn_level[b] == LVL_PRESSED && lvl_new == LVL_HOLD) ev = EV_HOLD;
      else if (btn_level[b] == LVL_PRESSED && lvl_new == LVL_RELEASED) ev = EV_RELEASED;
      else if (btn_level[b] == LVL_HOLD && lvl_new == LVL_RELEASED) ev = EV_HOLD_RELEASED;
      // highest button wins
      if (ev != EV_NONE) begin
        r.button = button_t'(b);
        r.kind   = ev;
      end
      btn_level[b] = lvl_new;
    end
    r.zero = (BUTTONS > 0) ? btn_level[0] : LVL_RELEASED;
    r.one  = (BUTTONS > 1) ? btn_level[1] : LVL_RELEASED;
    r.two  = (BUTTONS > 2) ? btn_level[2] : LVL_RELEASED;
    return r;
  endfunction

  // offer one sample, with random gaps, and record its expected result on acceptance
  task automatic send_sample(input sample_t s);
    if ($urandom_range(0, 99) < in_idle_pct) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < in_idle_pct);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= 16'(s);
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pending_results.push_back(debounce_step(s));
    samples_sent++;
  endtask

  // drop valid and wait until every expected result has come back
  task automatic drain_pipeline();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // setup and access cycle; the bus is left selected for a following write
  task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    case (idx)
      REG_WIN0_LOW:    win_lo[0] = value[SAMPLE_W-1:0];
      REG_WIN0_HIGH:   win_hi[0] = value[SAMPLE_W-1:0];
      REG_WIN1_LOW:    win_lo[1] = value[SAMPLE_W-1:0];
      REG_WIN1_HIGH:   win_hi[1] = value[SAMPLE_W-1:0];
      REG_WIN2_LOW:    win_lo[2] = value[SAMPLE_W-1:0];
      REG_WIN2_HIGH:   win_hi[2] = value[SAMPLE_W-1:0];
      REG_PRESS_AFTER: press_th  = value[COUNT_W-1:0];
      REG_HOLD_AFTER:  hold_th   = value[COUNT_W-1:0];
      default: ;
    endcase
  endtask

  // write every register; call only with nothing in flight
  task automatic set_config(input int lo0, input int hi0, input int lo1, input int hi1,
                            input int lo2, input int hi2, input int press, input int hold);
    write_reg(REG_WIN0_LOW,    32'(lo0));
    write_reg(REG_WIN0_HIGH,   32'(hi0));
    write_reg(REG_WIN1_LOW,    32'(lo1));
    write_reg(REG_WIN1_HIGH,   32'(hi1));
    write_reg(REG_WIN2_LOW,    32'(lo2));
    write_reg(REG_WIN2_HIGH,   32'(hi2));
    write_reg(REG_PRESS_AFTER, 32'(press));
    write_reg(REG_HOLD_AFTER,  32'(hold));
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  function automatic sample_t pick_in_window(input int slot);
    if (int'(win_hi[slot]) > int'(win_lo[slot]) + 1)
      return sample_t'($urandom_range(int'(win_lo[slot]) + 1, int'(win_hi[slot]) - 1));
    return sample_t'($urandom_range(0, 4095));
  endfunction

  // random window for one slot, clamped to the sample range
  task automatic random_window(output int lo, output int hi);
    lo = $urandom_range(0, 3800);
    hi = lo + $urandom_range(2, 280);
    if (hi > 4095) hi = 4095;
  endtask

  // key presses: runs of in-window samples, some long enough to saturate, mixed with noise
  task automatic send_runs(input int n_items);
    int      sent;
    int      run_len;
    int      slot;
    int      k;
    sample_t s;
    sent = 0;
    while (sent < n_items) begin
      slot = $urandom_range(0, 3);
      if (slot == 3) run_len = $urandom_range(1, 3);
      else if ($urandom_range(0, 7) == 0) run_len = $urandom_range(40, 56);
      else run_len = $urandom_range(1, int'(hold_th) + 4);
      for (k = 0; k < run_len && sent < n_items; k++) begin
        if (slot == 3 || $urandom_range(0, 19) == 0) s = sample_t'($urandom_range(0, 4095));
        else s = pick_in_window(slot);
        send_sample(s);
        sent++;
      end
    end
  endtask

  // window bounds and every event kind at reset settings
  task automatic test_directed_levels();
    sample_t seq[$];
    seq = '{12'd0, 12'd4095, 12'd280, 12'd380, 12'd281, 12'd379,
            12'd330, 12'd330, 12'd330, 12'd330, 12'd330, 12'd330, 12'd330, 12'd330, 12'd330,
            12'd4095, 12'd660, 12'd709, 12'd0, 12'd451, 12'd549, 12'd610};
    foreach (seq[i]) send_sample(seq[i]);
    drain_pipeline();
  endtask

  // empty and inverted windows, released straight to hold, hold back to pressed
  task automatic test_odd_thresholds();
    set_config(100, 101, 4095, 0, 450, 550, 63, 0);
    send_sample(12'd100);
    send_sample(12'd101);
    send_sample(12'd500);
    drain_pipeline();
    set_config(100, 101, 4095, 0, 450, 550, 0, 63);
    send_sample(12'd500);
    send_sample(12'd4095);
    send_sample(12'd0);
    drain_pipeline();
  endtask

  task automatic test_random_reset_config();
    set_config(WIN0_LOW_RST, WIN0_HIGH_RST, WIN1_LOW_RST, WIN1_HIGH_RST,
               WIN2_LOW_RST, WIN2_HIGH_RST, PRESS_AFTER_RST, HOLD_AFTER_RST);
    in_idle_pct  = 12;
    out_idle_pct = 66;
    send_runs(180);
    drain_pipeline();
  endtask

  // random windows; hold the receiver off for a long stretch so the input backs up
  task automatic test_random_windows_backpressure();
    int lo0, hi0, lo1, hi1, lo2, hi2, press;
    random_window(lo0, hi0);
    random_window(lo1, hi1);
    random_window(lo2, hi2);
    press = $urandom_range(0, 6);
    set_config(lo0, hi0, lo1, hi1, lo2, hi2, press, press + $urandom_range(0, 12));
    in_idle_pct  = 66;
    out_idle_pct = 12;
    hold_off_seq++;
    send_runs(180);
    drain_pipeline();
  endtask

  // window from 0 to 4095 on button zero, lowest press and hold just under saturation
  task automatic test_random_wide_open();
    int lo1, hi1, lo2, hi2;
    random_window(lo1, hi1);
    random_window(lo2, hi2);
    set_config(0, 4095, lo1, hi1, lo2, hi2, 0, COUNT_LIMIT - 1);
    in_idle_pct  = 0;
    out_idle_pct = 0;
    send_runs(180);
    drain_pipeline();
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  // receiver: random stalls, long hold-off on request, compare each result transaction
  always @(posedge clk) begin
    ladder_result_t got;
    ladder_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.button = out_tdata[1:0];
      got.kind   = out_tdata[4:2];
      got.zero   = out_tdata[6:5];
      got.one    = out_tdata[8:7];
      got.two    = out_tdata[10:9];
      results_seen++;
      if (got.kind <= EV_HOLD_RELEASED) kind_seen[got.kind]++;
      if (pending_results.size() == 0) begin
        $error("result transaction with no sample outstanding: tdata %h", out_tdata);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        check_field("event_button", want.button, got.button);
        check_field("event_kind",   want.kind,   got.kind);
        check_field("state_zero",   want.zero,   got.zero);
        check_field("state_one",    want.one,    got.one);
        check_field("state_two",    want.two,    got.two);
      end
    end
    if (hold_off_seen != hold_off_seq) begin
      hold_off_seen <= hold_off_seq;
      stall_left    <= HOLD_OFF_CYCLES;
      out_tready    <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= out_idle_pct);
    end
  end

  // watchdog: end the run when no transaction moves for too long
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_psel) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("timeout: no transaction for %0d cycles, %0d results outstanding",
                 QUIET_LIMIT, pending_results.size());
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    test_directed_levels();
    test_odd_thresholds();
    test_random_reset_config();
    test_random_windows_backpressure();
    test_random_wide_open();
    drain_pipeline();
    repeat (8) @(posedge clk);
    $display("Covered %0d samples and %0d results over six register settings, with a long",
             samples_sent, results_seen);
    $display("output stall; events none %0d, pressed %0d, hold %0d, released %0d, after hold %0d",
             kind_seen[0], kind_seen[1], kind_seen[2], kind_seen[3], kind_seen[4]);
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
